// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FMBQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fmbq: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define FMBQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fmbq: next-cycle check failed");

`endif

// ----- rtl/fmbq_pkg.sv -----
`default_nettype none

package fmbq_pkg;

	localparam int unsigned MODE_W   = 3;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned FILL_W   = 9;

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_MID   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_POP_MID    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd5;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

	typedef logic [DATA_W-1:0] data_t;

	// Broadcast to every cell: open a gap at the index, or close the gap there.
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/fmbq_in_if.sv -----
`default_nettype none

interface fmbq_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [fmbq_pkg::MODE_W-1:0]           mode;
	logic signed [fmbq_pkg::DATA_W-1:0]    value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/fmbq_out_if.sv -----
`default_nettype none

interface fmbq_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [fmbq_pkg::DATA_W-1:0]    popped_value;
	logic [fmbq_pkg::STATUS_W-1:0]         status;
	logic [fmbq_pkg::FILL_W-1:0]           fill_count;

	modport source (output valid, output popped_value, output status, output fill_count,
		input ready);
	modport sink (input valid, input popped_value, input status, input fill_count,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/front_middle_back_queue_top.sv -----
// Bounded ordered queue of signed 32-bit elements with push and pop at the
// front, the middle and the back. Each request gives exactly one response:
// the popped element (or -1 with an empty status), a full status when a push
// is dropped, and the element count after the operation. A request's response
// is loaded into the output register at the same edge that accepts the request
// and is offered from the following cycle, so the block sustains one request
// per cycle whenever the response side keeps up. That figure is set by the row
// of CAPACITY cells, which all shift by one place at the same edge around the
// computed index. Index zero is the front of the queue. There is no clearing
// pass after reset; only the count and the output valid flag are cleared.

`default_nettype none

`include "assert_macros.svh"

module front_middle_back_queue_top #(
	parameter int unsigned CAPACITY = 256
) (
	input  wire          clk,
	input  wire          arst_n,
	fmbq_in_if.sink      req,
	fmbq_out_if.source   rsp
);

	// The index width covers every cell; the count also has to hold CAPACITY.
	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	// Request handshake. The output register is free when it is empty or
	// when its response is being taken in this same cycle.
	logic fire;
	logic out_valid_q;

	assign req.ready = !out_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	// Control: count, shift command and the shared index.
	fmbq_pkg::cell_cmd_t            cmd;
	logic [IDX_W-1:0]               pos;
	logic [fmbq_pkg::STATUS_W-1:0]  status;
	logic [CNT_W-1:0]               cnt;
	logic [CNT_W-1:0]               cnt_nxt;

	fmbq_ctrl #(
		.CAPACITY (CAPACITY),
		.IDX_W    (IDX_W),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.mode    (req.mode),
		.cmd     (cmd),
		.pos     (pos),
		.status  (status),
		.cnt     (cnt),
		.cnt_nxt (cnt_nxt)
	);

	// The cell row. Each cell sees its left and right neighbours; the ends
	// are fed with zero, which only ever lands in slots beyond the count.
	fmbq_pkg::data_t cell_val [CAPACITY];
	fmbq_pkg::data_t cell_rd  [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		fmbq_pkg::data_t left_val;
		fmbq_pkg::data_t right_val;

		if (i == 0) begin : g_first
			assign left_val = '0;
		end else begin : g_inner_l
			assign left_val = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_inner_r
			assign right_val = cell_val[i+1];
		end

		fmbq_cell #(
			.IDX_W (IDX_W),
			.IDX   (i)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.pos       (pos),
			.left_val  (left_val),
			.right_val (right_val),
			.new_val   (req.value),
			.val       (cell_val[i]),
			.rd_val    (cell_rd[i])
		);
	end

	// Only the cell at the index offers a non-zero word, so an OR across the
	// row picks the element that a pop removes.
	fmbq_pkg::data_t rd_all;

	always_comb begin
		rd_all = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_all = rd_all | cell_rd[i];
		end
	end

	// Response word. A successful pop returns the element, a pop on an empty
	// queue returns minus one, and everything else returns zero. The count is
	// reported through its low nine bits.
	logic signed [fmbq_pkg::DATA_W-1:0] popped_d;
	logic [CNT_W+fmbq_pkg::FILL_W-1:0]  cnt_ext;

	always_comb begin
		popped_d = '0;
		if (cmd.rem) begin
			popped_d = rd_all;
		end else if (status == fmbq_pkg::STATUS_EMPTY) begin
			popped_d = fmbq_pkg::EMPTY_VALUE;
		end
	end

	assign cnt_ext = {{fmbq_pkg::FILL_W{1'b0}}, cnt_nxt};

	logic signed [fmbq_pkg::DATA_W-1:0] popped_q;
	logic [fmbq_pkg::STATUS_W-1:0]      status_q;
	logic [fmbq_pkg::FILL_W-1:0]        fill_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			popped_q <= popped_d;
			status_q <= status;
			fill_q   <= cnt_ext[fmbq_pkg::FILL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.popped_value = popped_q;
	assign rsp.status       = status_q;
	assign rsp.fill_count   = fill_q;

	// The count never goes past the number of cells.
	`FMBQ_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt <= CAP_C)

	// Every accepted request leaves a response in the output register.
	`FMBQ_ASSERT_NEXT(a_rsp_loaded, clk, arst_n, fire, out_valid_q)

	// A pop on an empty queue reports empty and leaves the count alone.
	`FMBQ_ASSERT_NEXT(a_empty_pop, clk, arst_n,
		fire && (status == fmbq_pkg::STATUS_EMPTY),
		(status_q == fmbq_pkg::STATUS_EMPTY) && (cnt == '0))

	// A push that finds room grows the count by exactly one.
	`FMBQ_ASSERT_NEXT(a_push_grows, clk, arst_n, cmd.ins,
		cnt == $past(cnt) + CNT_W'(1))

endmodule

`default_nettype wire

// ----- rtl/fmbq_cell.sv -----
`default_nettype none

// One slot of the queue. It holds its element, takes a neighbour's element
// when the row shifts, and offers its element when the shared index names it.
module fmbq_cell #(
	parameter int unsigned IDX_W = 8,
	parameter int unsigned IDX   = 0
) (
	input  wire                     clk,
	input  wire fmbq_pkg::cell_cmd_t cmd,
	input  wire [IDX_W-1:0]         pos,
	input  wire fmbq_pkg::data_t    left_val,
	input  wire fmbq_pkg::data_t    right_val,
	input  wire fmbq_pkg::data_t    new_val,
	output fmbq_pkg::data_t         val,
	output fmbq_pkg::data_t         rd_val
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	fmbq_pkg::data_t val_q;
	logic            at_pos;
	logic            past_pos;

	assign at_pos   = (pos == MY_IDX);
	assign past_pos = (MY_IDX > pos);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (at_pos) begin
				val_q <= new_val;
			end else if (past_pos) begin
				val_q <= left_val;
			end
		end else if (cmd.rem && (at_pos || past_pos)) begin
			val_q <= right_val;
		end
	end

	assign val    = val_q;
	assign rd_val = at_pos ? val_q : '0;

endmodule

`default_nettype wire

// ----- rtl/fmbq_ctrl.sv -----
`default_nettype none

// Holds the element count and turns each request into a shift command and
// the index that the cell row works around.
module fmbq_ctrl #(
	parameter int unsigned CAPACITY = 256,
	parameter int unsigned IDX_W    = 8,
	parameter int unsigned CNT_W    = 9
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               fire,
	input  wire [fmbq_pkg::MODE_W-1:0]        mode,
	output fmbq_pkg::cell_cmd_t               cmd,
	output logic [IDX_W-1:0]                  pos,
	output logic [fmbq_pkg::STATUS_W-1:0]     status,
	output logic [CNT_W-1:0]                  cnt,
	output logic [CNT_W-1:0]                  cnt_nxt
);

	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] pos_w;
	logic             is_push;
	logic             is_pop;
	logic             full;
	logic             empty;

	assign full  = (cnt_q == CAP_C);
	assign empty = (cnt_q == '0);

	always_comb begin
		is_push = 1'b0;
		is_pop  = 1'b0;
		pos_w   = '0;
		case (mode)
			fmbq_pkg::MODE_PUSH_FRONT: begin
				is_push = 1'b1;
			end
			fmbq_pkg::MODE_PUSH_MID: begin
				is_push = 1'b1;
				pos_w   = cnt_q >> 1;
			end
			fmbq_pkg::MODE_PUSH_BACK: begin
				is_push = 1'b1;
				pos_w   = cnt_q;
			end
			fmbq_pkg::MODE_POP_FRONT: begin
				is_pop = 1'b1;
			end
			fmbq_pkg::MODE_POP_MID: begin
				is_pop = 1'b1;
				pos_w  = (cnt_q - ONE_C) >> 1;
			end
			fmbq_pkg::MODE_POP_BACK: begin
				is_pop = 1'b1;
				pos_w  = cnt_q - ONE_C;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		status = fmbq_pkg::STATUS_OK;
		if (is_push && full) begin
			status = fmbq_pkg::STATUS_FULL;
		end else if (is_pop && empty) begin
			status = fmbq_pkg::STATUS_EMPTY;
		end
	end

	assign cmd.ins = fire && is_push && !full;
	assign cmd.rem = fire && is_pop && !empty;
	assign pos     = pos_w[IDX_W-1:0];

	always_comb begin
		cnt_nxt = cnt_q;
		if (cmd.ins) begin
			cnt_nxt = cnt_q + ONE_C;
		end else if (cmd.rem) begin
			cnt_nxt = cnt_q - ONE_C;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_nxt;
		end
	end

	assign cnt = cnt_q;

endmodule

`default_nettype wire

// ----- test/fmbq_result_checker.sv -----
module fmbq_result_checker #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	fmbq_in_if          req,
	fmbq_out_if         rsp,
	output int unsigned fail_count,
	output int unsigned pending_count
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [fmbq_pkg::DATA_W-1:0] popped_value;
		logic [fmbq_pkg::STATUS_W-1:0]      status;
		logic [fmbq_pkg::FILL_W-1:0]        fill_count;
	} response_t;

	// Mirror of the queue contents, index zero at the front.
	logic signed [fmbq_pkg::DATA_W-1:0] held_elements[$];
	// Responses predicted for accepted requests, oldest first.
	response_t                          awaited_responses[$];

	function automatic response_t apply_operation(input logic [fmbq_pkg::MODE_W-1:0] mode,
			input logic signed [fmbq_pkg::DATA_W-1:0] value);
		response_t r;
		int        n;
		int        pos;
		n = held_elements.size();
		r.popped_value = '0;
		r.status = fmbq_pkg::STATUS_OK;
		case (mode)
			fmbq_pkg::MODE_PUSH_FRONT, fmbq_pkg::MODE_PUSH_MID,
			fmbq_pkg::MODE_PUSH_BACK: begin
				if (n >= int'(CAPACITY)) begin
					r.status = fmbq_pkg::STATUS_FULL;
				end else begin
					pos = (mode == fmbq_pkg::MODE_PUSH_FRONT) ? 0 :
						(mode == fmbq_pkg::MODE_PUSH_MID) ? n / 2 : n;
					held_elements.insert(pos, value);
				end
			end
			fmbq_pkg::MODE_POP_FRONT, fmbq_pkg::MODE_POP_MID,
			fmbq_pkg::MODE_POP_BACK: begin
				if (n == 0) begin
					r.popped_value = fmbq_pkg::EMPTY_VALUE;
					r.status = fmbq_pkg::STATUS_EMPTY;
				end else begin
					pos = (mode == fmbq_pkg::MODE_POP_FRONT) ? 0 :
						(mode == fmbq_pkg::MODE_POP_MID) ? (n - 1) / 2 : n - 1;
					r.popped_value = held_elements[pos];
					held_elements.delete(pos);
				end
			end
			default: ;
		endcase
		r.fill_count = fmbq_pkg::FILL_W'(held_elements.size());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		response_t   oldest;
		int unsigned faults;
		if (!arst_n) begin
			held_elements.delete();
			awaited_responses.delete();
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			faults = 0;
			// The response is registered, so a response seen at this edge always belongs
			// to a request accepted at an earlier edge; check it before predicting.
			if (rsp.valid && rsp.ready) begin
				if (awaited_responses.size() == 0) begin
					$error("unexpected response: popped_value %0d status %0d fill_count %0d",
						rsp.popped_value, rsp.status, rsp.fill_count);
					faults++;
				end else begin
					oldest = awaited_responses[0];
					awaited_responses.delete(0);
					if (rsp.popped_value !== oldest.popped_value) begin
						$error("popped_value: expected %0d, got %0d",
							oldest.popped_value, rsp.popped_value);
						faults++;
					end
					if (rsp.status !== oldest.status) begin
						$error("status: expected %0d, got %0d", oldest.status, rsp.status);
						faults++;
					end
					if (rsp.fill_count !== oldest.fill_count) begin
						$error("fill_count: expected %0d, got %0d",
							oldest.fill_count, rsp.fill_count);
						faults++;
					end
				end
			end
			if (req.valid && req.ready)
				awaited_responses.insert(awaited_responses.size(),
					apply_operation(req.mode, req.value));
			fail_count <= fail_count + faults;
			pending_count <= awaited_responses.size();
		end
	end

endmodule

// ----- test/tb.sv -----
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAPACITY         = 256;
	localparam int unsigned RANDOM_REQUESTS  = 620;
	localparam int unsigned LONG_HOLD_CYCLES = 200;
	localparam int unsigned HOLD_AFTER       = 300;
	localparam int unsigned CYCLE_LIMIT      = 400000;
	localparam int unsigned SETTLE_CYCLES    = 8;

	// The two mode codes that the block must ignore.
	localparam logic [fmbq_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd6;
	localparam logic [fmbq_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	localparam logic [fmbq_pkg::MODE_W-1:0] PUSH_MODES [3] =
		'{fmbq_pkg::MODE_PUSH_FRONT, fmbq_pkg::MODE_PUSH_MID, fmbq_pkg::MODE_PUSH_BACK};
	localparam logic [fmbq_pkg::MODE_W-1:0] POP_MODES  [3] =
		'{fmbq_pkg::MODE_POP_FRONT, fmbq_pkg::MODE_POP_MID, fmbq_pkg::MODE_POP_BACK};

	typedef struct {
		logic [fmbq_pkg::MODE_W-1:0]        mode;
		logic signed [fmbq_pkg::DATA_W-1:0] value;
	} request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned fail_count;
	int unsigned pending_results;

	fmbq_in_if  req_bus ();
	fmbq_out_if rsp_bus ();

	front_middle_back_queue_top #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	// The checker sits beside the block, watches both channels, keeps its own copy
	// of the queue and reports how many mismatches it has seen.
	fmbq_result_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus),
		.fail_count(fail_count),
		.pending_count(pending_results)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Requests waiting to be offered to the block, in order.
	request_t request_plan[$];

	task automatic add_request(input logic [fmbq_pkg::MODE_W-1:0] m,
			input logic signed [fmbq_pkg::DATA_W-1:0] v);
		request_t item;
		item.mode  = m;
		item.value = v;
		request_plan.insert(request_plan.size(), item);
	endtask

	// Mostly uniform values, with the extremes and the all-ones pattern mixed in often,
	// so that every bit of the value field is seen both low and high.
	function automatic logic signed [fmbq_pkg::DATA_W-1:0] random_value();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh0000_0000;
			3: return 32'shFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [fmbq_pkg::MODE_W-1:0] spare_mode();
		return $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
	endfunction

	// Holds the request on the bus until the block takes it. Valid is left high so
	// that a following request in the same burst goes out on the very next cycle.
	task automatic send_request(input request_t item);
		req_bus.valid <= 1'b1;
		req_bus.mode  <= item.mode;
		req_bus.value <= item.value;
		do @(posedge clk); while (!req_bus.ready);
	endtask

	// Offers the whole plan in bursts of random length. Gaps between bursts are
	// sometimes zero, which gives long stretches with no idling on the input side.
	task automatic drive_plan();
		int unsigned burst;
		int unsigned gap;
		request_t    item;
		while (request_plan.size() != 0) begin
			burst = $urandom_range(1, 24);
			while (burst != 0 && request_plan.size() != 0) begin
				item = request_plan[0];
				request_plan.delete(0);
				send_request(item);
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_bus.valid <= 1'b0;
	endtask

	// Short directed opening: pops on an empty queue, the ignored modes, extreme
	// values pushed at every position, middle pops on odd and even counts, and a
	// drain back to empty followed by one more empty pop.
	task automatic plan_directed();
		add_request(fmbq_pkg::MODE_POP_FRONT, 32'sh1234_5678);
		add_request(fmbq_pkg::MODE_POP_MID, 32'sh0000_0000);
		add_request(fmbq_pkg::MODE_POP_BACK, 32'shFFFF_FFFF);
		add_request(MODE_SPARE_LO, 32'sh7FFF_FFFF);
		add_request(MODE_SPARE_HI, 32'sh8000_0000);
		add_request(fmbq_pkg::MODE_PUSH_BACK, 32'sh7FFF_FFFF);
		add_request(fmbq_pkg::MODE_PUSH_FRONT, 32'sh8000_0000);
		add_request(fmbq_pkg::MODE_PUSH_MID, 32'sh0000_0000);
		add_request(fmbq_pkg::MODE_PUSH_MID, 32'shFFFF_FFFF);
		add_request(fmbq_pkg::MODE_PUSH_BACK, 32'sh5555_5555);
		add_request(fmbq_pkg::MODE_PUSH_FRONT, 32'shAAAA_AAAA);
		add_request(fmbq_pkg::MODE_POP_MID, 32'sh0000_0000);
		add_request(fmbq_pkg::MODE_PUSH_MID, 32'sh0000_0001);
		add_request(fmbq_pkg::MODE_POP_FRONT, 32'sh0000_0000);
		add_request(fmbq_pkg::MODE_POP_BACK, 32'sh0000_0000);
		add_request(fmbq_pkg::MODE_POP_MID, 32'sh0000_0000);
		add_request(MODE_SPARE_HI, 32'shFFFF_FFFF);
		add_request(fmbq_pkg::MODE_POP_MID, 32'sh0000_0000);
		add_request(fmbq_pkg::MODE_POP_MID, 32'sh0000_0000);
		add_request(fmbq_pkg::MODE_POP_MID, 32'sh0000_0000);
		add_request(fmbq_pkg::MODE_POP_BACK, 32'sh0000_0000);
	endtask

	// Fills the queue to capacity and beyond, so that a run of pushes is dropped
	// as full. The odd pop sprinkled in costs one extra push to keep the fill going.
	task automatic plan_fill();
		int unsigned pushes_needed;
		pushes_needed = CAPACITY + 24;
		while (pushes_needed != 0) begin
			if ($urandom_range(0, 9) == 0) begin
				add_request(POP_MODES[$urandom_range(0, 2)], random_value());
				pushes_needed++;
			end
			if ($urandom_range(0, 49) == 0)
				add_request(spare_mode(), random_value());
			add_request(PUSH_MODES[$urandom_range(0, 2)], random_value());
			pushes_needed--;
		end
	endtask

	// The mirror image: empties the full queue and pops a few more on empty.
	task automatic plan_drain();
		int unsigned pops_needed;
		pops_needed = CAPACITY + 8;
		while (pops_needed != 0) begin
			if ($urandom_range(0, 9) == 0) begin
				add_request(PUSH_MODES[$urandom_range(0, 2)], random_value());
				pops_needed++;
			end
			add_request(POP_MODES[$urandom_range(0, 2)], random_value());
			pops_needed--;
		end
	endtask

	// Free mixing in segments that lean towards pushes, towards pops, or neither,
	// so that the count wanders over a wide range rather than hovering near zero.
	task automatic plan_random_mix();
		int unsigned planned;
		int unsigned segment;
		int unsigned push_share;
		int unsigned roll;
		planned = 0;
		while (planned < RANDOM_REQUESTS) begin
			segment = $urandom_range(30, 90);
			case ($urandom_range(0, 2))
				0: push_share = 70;
				1: push_share = 30;
				default: push_share = 50;
			endcase
			repeat (segment) begin
				roll = $urandom_range(0, 99);
				if (roll >= 98) begin
					// Ignored by the block, so not counted towards the total.
					add_request(spare_mode(), random_value());
				end else begin
					if (roll < push_share)
						add_request(PUSH_MODES[$urandom_range(0, 2)], random_value());
					else
						add_request(POP_MODES[$urandom_range(0, 2)], random_value());
					planned++;
				end
			end
		end
	endtask

	// Request side: reset, the directed opening with fill and drain, a full pause
	// until every response is back, the random mix, then the verdict.
	initial begin : stimulus
		req_bus.valid = 1'b0;
		req_bus.mode  = fmbq_pkg::MODE_PUSH_FRONT;
		req_bus.value = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan_directed();
		plan_fill();
		plan_drain();
		drive_plan();

		// The sender stops here until the checker has nothing outstanding.
		do @(posedge clk); while (pending_results != 0);

		plan_random_mix();
		drive_plan();

		// Every request is in; wait for the last responses and give the block a few
		// more cycles in which any stray response would show up.
		do @(posedge clk); while (pending_results != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Response side: ready follows a changing pattern (always ready, coin toss,
	// rarely ready, mostly ready), each held for a stretch of random length. Once,
	// after enough responses have gone by, ready is held low for a long time while
	// the sender keeps offering requests, so the output register fills and the
	// block has to stall its input.
	initial begin : response_side
		int unsigned stretch;
		int unsigned style;
		int unsigned responses_seen;
		bit          long_hold_done;
		responses_seen = 0;
		long_hold_done = 1'b0;
		rsp_bus.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			style = $urandom_range(0, 3);
			stretch = $urandom_range(10, 80);
			repeat (stretch) begin
				case (style)
					0: rsp_bus.ready <= 1'b1;
					1: rsp_bus.ready <= 1'($urandom_range(0, 1));
					2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
				endcase
				@(posedge clk);
				if (rsp_bus.valid && rsp_bus.ready)
					responses_seen++;
			end
			if (!long_hold_done && responses_seen >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				rsp_bus.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	// Guard against a hang: a run that reaches CYCLE_LIMIT is reported as failed.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
